// ===== rtl/core/qbe_pkg.sv =====
// Shared types, constants and helpers of the quantize-and-bitpack encoder.
package qbe_pkg;

  localparam int unsigned CFG_W      = 32;
  localparam int unsigned LEVEL_W    = 17;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned WID_W      = 5;
  localparam int unsigned OVL_W      = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;
  localparam int unsigned ACC_BYTES  = 3;

  localparam logic [CFG_W-1:0]   RANGE_LOW_RST   = 32'hFFF6_0000;
  localparam logic [CFG_W-1:0]   RANGE_HIGH_RST  = 32'h000A_0000;
  localparam logic [CFG_W-1:0]   INV_STEP_RST    = 32'd838861;
  localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RST = 17'd256;

  typedef enum logic [1:0] {
    REG_RANGE_LOW   = 2'd0,
    REG_RANGE_HIGH  = 2'd1,
    REG_INV_STEP    = 2'd2,
    REG_LEVEL_COUNT = 2'd3
  } qbe_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0]   range_low;
    logic [CFG_W-1:0]   range_high;
    logic [CFG_W-1:0]   inv_step;
    logic [LEVEL_W-1:0] level_count;
  } qbe_cfg_t;

  // One classified sample on its way to the packer.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [WID_W-1:0] width;
    logic             last;
    logic [OVL_W-1:0] ovl;
  } qbe_item_t;

  // Bits needed for indexes 0..levels-1, given levels-1 (at least 1).
  function automatic logic [WID_W-1:0] idx_width(input logic [IDX_W-1:0] max_idx);
    logic [WID_W-1:0] w;
    w = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (max_idx[i]) w = WID_W'(i + 1);
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/quantize_and_bitpack_encoder.sv =====
// A sample passes the range-check and multiply registers, the queue and the packer's result
// list before its first result beat is shown. The packer issues one result beat per cycle
// while the receiver is ready; a sample has 0 to 3 results.
// The classifier is a 2-stage pipe (range check, then reciprocal multiply) feeding a
// 4-entry queue; a sample enters whenever the queue has credit.
// Reset (asynchronous, active low) restores the default config and clears the pipeline, queue and packer control state.
module quantize_and_bitpack_encoder #(
  parameter int unsigned MAX_PACKET_BYTES = 64,
  parameter int unsigned MAX_LEVELS       = 65536,
  parameter int unsigned SAMPLE_WIDTH     = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [1:0]                                cfg_idx_i,
  input  logic [qbe_pkg::CFG_W-1:0]                 cfg_data_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]                   sample_value_i,
  input  logic                                      last_sample_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [7:0]                                data_byte_o,
  output logic                                      byte_valid_o,
  output logic                                      end_of_packet_o,
  output logic [$clog2(MAX_PACKET_BYTES*8+1)-1:0]   packet_bits_o,
  output logic [qbe_pkg::OVL_W-1:0]                 overload_total_o
);

  localparam int unsigned BPW = $clog2(MAX_PACKET_BYTES*8+1);

  qbe_pkg::qbe_cfg_t                cfg_q;
  qbe_pkg::qbe_item_t               push_item, head_item;
  logic                             push, pop, not_empty;
  logic [qbe_pkg::FIFO_CNT_W-1:0]   fifo_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low   <= qbe_pkg::RANGE_LOW_RST;
      cfg_q.range_high  <= qbe_pkg::RANGE_HIGH_RST;
      cfg_q.inv_step    <= qbe_pkg::INV_STEP_RST;
      cfg_q.level_count <= qbe_pkg::LEVEL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (qbe_pkg::qbe_reg_e'(cfg_idx_i))
        qbe_pkg::REG_RANGE_LOW:   cfg_q.range_low   <= cfg_data_i;
        qbe_pkg::REG_RANGE_HIGH:  cfg_q.range_high  <= cfg_data_i;
        qbe_pkg::REG_INV_STEP:    cfg_q.inv_step    <= cfg_data_i;
        qbe_pkg::REG_LEVEL_COUNT: cfg_q.level_count <= cfg_data_i[qbe_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  qbe_front #(
    .MAX_LEVELS  (MAX_LEVELS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_value_i(sample_value_i),
    .last_sample_i (last_sample_i),
    .fifo_count_i  (fifo_count),
    .push_o        (push),
    .item_o        (push_item)
  );

  qbe_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (push_item),
    .pop_i      (pop),
    .head_o     (head_item),
    .not_empty_o(not_empty),
    .count_o    (fifo_count)
  );

  qbe_back #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .BPW             (BPW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_item),
    .not_empty_i     (not_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .data_byte_o     (data_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_packet_o (end_of_packet_o),
    .packet_bits_o   (packet_bits_o),
    .overload_total_o(overload_total_o)
  );

endmodule

// ===== rtl/core/qbe_front.sv =====
// Front end: range check, reciprocal multiply and rounding to a level index.
module qbe_front #(
  parameter int unsigned MAX_LEVELS   = 65536,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qbe_pkg::qbe_cfg_t                    cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]              sample_value_i,
  input  logic                                 last_sample_i,
  input  logic [qbe_pkg::FIFO_CNT_W-1:0]       fifo_count_i,
  output logic                                 push_o,
  output qbe_pkg::qbe_item_t                   item_o
);

  localparam int unsigned CW = (SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32;
  localparam int unsigned XW = CW + 1;

  logic                          accept;
  logic signed [XW-1:0]          v_x, lo_x, hi_x, diff_x;
  logic                          lt, gt;
  logic [qbe_pkg::OVL_W-1:0]     ovl_q, ovl_d;
  logic [qbe_pkg::FIFO_CNT_W-1:0] in_flight;

  logic                          s1_v_q, s1_lt_q, s1_gt_q, s1_last_q;
  logic [31:0]                   s1_diff_q;
  logic [qbe_pkg::OVL_W-1:0]     s1_ovl_q;

  logic                          s2_v_q, s2_lt_q, s2_gt_q, s2_last_q;
  logic [qbe_pkg::PROD_W-1:0]    s2_prod_q;
  logic [qbe_pkg::OVL_W-1:0]     s2_ovl_q;

  logic [qbe_pkg::LEVEL_W-1:0]   lvl;
  logic [qbe_pkg::IDX_W-1:0]     lvl_m1;
  logic [33:0]                   q_sum;
  logic [32:0]                   q;
  logic [qbe_pkg::IDX_W-1:0]     idx;

  // Credit check: everything in the pipe must fit in the queue.
  assign in_flight  = qbe_pkg::FIFO_CNT_W'(s1_v_q) + qbe_pkg::FIFO_CNT_W'(s2_v_q)
                    + fifo_count_i;
  assign in_ready_o = in_flight < qbe_pkg::FIFO_CNT_W'(qbe_pkg::FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  assign v_x    = XW'($signed(sample_value_i));
  assign lo_x   = XW'($signed(cfg_i.range_low));
  assign hi_x   = XW'($signed(cfg_i.range_high));
  assign lt     = v_x < lo_x;
  assign gt     = !lt && (v_x > hi_x);
  assign diff_x = v_x - lo_x;

  always_comb begin
    ovl_d = ovl_q;
    if (accept && (lt || gt) && (ovl_q != '1)) ovl_d = ovl_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovl_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      ovl_q  <= ovl_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_diff_q <= diff_x[31:0];
      s1_lt_q   <= lt;
      s1_gt_q   <= gt;
      s1_last_q <= last_sample_i;
      s1_ovl_q  <= ovl_d;
    end
    if (s1_v_q) begin
      s2_prod_q <= 64'(s1_diff_q) * 64'(cfg_i.inv_step);
      s2_lt_q   <= s1_lt_q;
      s2_gt_q   <= s1_gt_q;
      s2_last_q <= s1_last_q;
      s2_ovl_q  <= s1_ovl_q;
    end
  end

  always_comb begin
    if (cfg_i.level_count < qbe_pkg::LEVEL_W'(2)) begin
      lvl = qbe_pkg::LEVEL_W'(2);
    end else if (cfg_i.level_count > qbe_pkg::LEVEL_W'(MAX_LEVELS)) begin
      lvl = qbe_pkg::LEVEL_W'(MAX_LEVELS);
    end else begin
      lvl = cfg_i.level_count;
    end
  end

  assign lvl_m1 = qbe_pkg::IDX_W'(lvl - 1'b1);
  // Round half up on the Q32.32 product.
  assign q_sum  = {1'b0, s2_prod_q[63:31]} + 34'd1;
  assign q      = q_sum[33:1];

  always_comb begin
    if (s2_lt_q) begin
      idx = '0;
    end else if (s2_gt_q || (q >= 33'(lvl))) begin
      idx = lvl_m1;
    end else begin
      idx = q[qbe_pkg::IDX_W-1:0];
    end
  end

  assign push_o       = s2_v_q;
  assign item_o.idx   = idx;
  assign item_o.width = qbe_pkg::idx_width(lvl_m1);
  assign item_o.last  = s2_last_q;
  assign item_o.ovl   = s2_ovl_q;

endmodule

// ===== rtl/core/qbe_fifo.sv =====
// Short queue between the classifier and the packer.
module qbe_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  qbe_pkg::qbe_item_t             item_i,
  input  logic                           pop_i,
  output qbe_pkg::qbe_item_t             head_o,
  output logic                           not_empty_o,
  output logic [qbe_pkg::FIFO_CNT_W-1:0] count_o
);

  qbe_pkg::qbe_item_t                     slots_q [qbe_pkg::FIFO_DEPTH];
  logic [qbe_pkg::FIFO_PTR_W-1:0]         wr_q, rd_q;
  logic [qbe_pkg::FIFO_CNT_W-1:0]         cnt_q;
  logic                                   do_pop;

  assign not_empty_o = cnt_q != '0;
  assign do_pop      = pop_i && not_empty_o;
  assign head_o      = slots_q[rd_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + qbe_pkg::FIFO_CNT_W'(push_i) - qbe_pkg::FIFO_CNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/core/qbe_back.sv =====
// Back end: packs level indexes LSB first and issues one result beat per cycle while the receiver is ready.
module qbe_back #(
  parameter int unsigned MAX_PACKET_BYTES = 64,
  parameter int unsigned BPW              = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qbe_pkg::qbe_item_t         head_i,
  input  logic                       not_empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 data_byte_o,
  output logic                       byte_valid_o,
  output logic                       end_of_packet_o,
  output logic [BPW-1:0]             packet_bits_o,
  output logic [qbe_pkg::OVL_W-1:0]  overload_total_o
);

  localparam int unsigned CAP = MAX_PACKET_BYTES * 8;
  localparam int unsigned NW  = (BPW > qbe_pkg::WID_W) ? BPW : qbe_pkg::WID_W;
  localparam logic [BPW-1:0] CAP_L = BPW'(CAP);

  // Packet state.
  logic [2:0]     pc_q;
  logic [6:0]     pend_q;
  logic [BPW-1:0] bp_q;

  // Result list of the sample being issued.
  logic [qbe_pkg::ACC_BYTES-1:0][7:0] acc_q;
  logic [1:0]                         nbytes_q, pos_q, rem_q;
  logic                               flushv_q;
  logic [BPW-1:0]                     bits_q;
  logic [qbe_pkg::OVL_W-1:0]          ovl_q;

  logic                               out_v_q;
  logic [7:0]                         out_byte_q;
  logic                               out_bv_q, out_end_q;
  logic [BPW-1:0]                     out_bits_q;
  logic [qbe_pkg::OVL_W-1:0]          out_ovl_q;

  logic                               load_ok, emit, finishing, pop;
  logic [BPW-1:0]                     avail;
  logic [qbe_pkg::WID_W-1:0]          nb;
  logic [qbe_pkg::IDX_W-1:0]          idx_m;
  logic [qbe_pkg::ACC_BYTES*8-1:0]    acc_flat;
  logic [qbe_pkg::ACC_BYTES-1:0][7:0] acc_b;
  logic [qbe_pkg::WID_W-1:0]          total;
  logic [1:0]                         nbytes;
  logic [2:0]                         newpc;
  logic [BPW-1:0]                     bp_new;
  logic [7:0]                         rest;

  assign load_ok   = !out_v_q || out_ready_i;
  assign emit      = (rem_q != 2'd0) && load_ok;
  assign finishing = (rem_q == 2'd0) || ((rem_q == 2'd1) && emit);
  assign pop       = not_empty_i && finishing;
  assign pop_o     = pop;

  // Drop bits past the packet capacity.
  assign avail = CAP_L - bp_q;
  assign nb    = (NW'(head_i.width) > NW'(avail)) ? qbe_pkg::WID_W'(avail) : head_i.width;

  always_comb begin
    for (int i = 0; i < qbe_pkg::IDX_W; i++) begin
      idx_m[i] = head_i.idx[i] && (qbe_pkg::WID_W'(i) < nb);
    end
  end

  assign acc_flat = (qbe_pkg::ACC_BYTES*8)'(pend_q)
                  | ((qbe_pkg::ACC_BYTES*8)'(idx_m) << pc_q);
  assign acc_b    = acc_flat;
  assign total    = qbe_pkg::WID_W'(pc_q) + nb;
  assign nbytes   = total[4:3];
  assign newpc    = total[2:0];
  assign rest     = acc_b[nbytes];
  assign bp_new   = bp_q + BPW'(nb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      pend_q  <= '0;
      bp_q    <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pop) begin
        pos_q <= '0;
        rem_q <= nbytes + 2'(head_i.last);
        if (head_i.last) begin
          pc_q   <= '0;
          pend_q <= '0;
          bp_q   <= '0;
        end else begin
          pc_q   <= newpc;
          pend_q <= rest[6:0];
          bp_q   <= bp_new;
        end
      end else if (emit) begin
        pos_q <= pos_q + 1'b1;
        rem_q <= rem_q - 1'b1;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      acc_q    <= acc_b;
      nbytes_q <= nbytes;
      flushv_q <= newpc != 3'd0;
      bits_q   <= bp_new;
      ovl_q    <= head_i.ovl;
    end
    if (emit) begin
      out_byte_q <= acc_q[pos_q];
      out_ovl_q  <= ovl_q;
      if (pos_q < nbytes_q) begin
        out_bv_q   <= 1'b1;
        out_end_q  <= 1'b0;
        out_bits_q <= '0;
      end else begin
        out_bv_q   <= flushv_q;
        out_end_q  <= 1'b1;
        out_bits_q <= bits_q;
      end
    end
  end

  assign out_valid_o      = out_v_q;
  assign data_byte_o      = out_byte_q;
  assign byte_valid_o     = out_bv_q;
  assign end_of_packet_o  = out_end_q;
  assign packet_bits_o    = out_bits_q;
  assign overload_total_o = out_ovl_q;

endmodule

// ===== rtl/core/qbe_checker.sv =====
// Port-level checks of the encoder's result beats, bound to the top level.
module qbe_checker #(
  parameter int unsigned MAX_PACKET_BYTES = 64
) (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic [7:0]                              data_byte_o,
  input logic                                    byte_valid_o,
  input logic                                    end_of_packet_o,
  input logic [$clog2(MAX_PACKET_BYTES*8+1)-1:0] packet_bits_o,
  input logic [31:0]                             overload_total_o
);

  localparam int unsigned CAP = MAX_PACKET_BYTES * 8;

  // A stalled beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(end_of_packet_o) && $stable(overload_total_o))
    else $error("result beat changed while stalled");

  // Mid-packet beats are full payload bytes without a bit count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_packet_o |-> byte_valid_o && (packet_bits_o == '0))
    else $error("mid-packet beat malformed");

  // A flushed partial byte means the bit count is not a byte multiple, and the reverse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_packet_o |-> (byte_valid_o == (packet_bits_o[2:0] != 3'd0))
      && (byte_valid_o || (data_byte_o == 8'd0)))
    else $error("packet end beat inconsistent with bit count");

  // The bit count never exceeds the packet capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_packet_o |-> 32'(packet_bits_o) <= 32'(CAP))
    else $error("packet bit count beyond capacity");

endmodule

bind quantize_and_bitpack_encoder qbe_checker #(
  .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
) u_qbe_checker (.*);

// ===== tb/sv/quantize_and_bitpack_encoder_tb.sv =====
// Testbench for the quantize-and-bitpack encoder: random packets checked against a packing predictor.
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        end_of_packet;
  logic [9:0]  packet_bits;
  logic [31:0] overload_total;
} packed_beat_t;

class packing_scoreboard;
  localparam int unsigned PACKET_CAP = 512;
  localparam int unsigned LEVEL_MAX  = 65536;

  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic [31:0]        inv_step;
  logic [16:0]        level_count;

  logic [6:0]  pending_bits;
  logic [2:0]  pending_count;
  logic [9:0]  bit_position;
  logic [31:0] overload_tally;

  packed_beat_t expected_beats[$];
  int mismatches;
  int beats_checked;
  int samples_noted;
  int packets_closed;

  function new();
    range_low      = qbe_pkg::RANGE_LOW_RST;
    range_high     = qbe_pkg::RANGE_HIGH_RST;
    inv_step       = qbe_pkg::INV_STEP_RST;
    level_count    = qbe_pkg::LEVEL_COUNT_RST;
    pending_bits   = '0;
    pending_count  = '0;
    bit_position   = '0;
    overload_tally = '0;
    mismatches     = 0;
    beats_checked  = 0;
    samples_noted  = 0;
    packets_closed = 0;
  endfunction

  function void write_reg(qbe_pkg::qbe_reg_e idx, logic [31:0] data);
    case (idx)
      qbe_pkg::REG_RANGE_LOW:   range_low = data;
      qbe_pkg::REG_RANGE_HIGH:  range_high = data;
      qbe_pkg::REG_INV_STEP:    inv_step = data;
      qbe_pkg::REG_LEVEL_COUNT: level_count = data[16:0];
      default: ;
    endcase
  endfunction

  function void push_beat(logic [7:0] data, logic valid, logic eop, logic [9:0] bits);
    packed_beat_t beat;
    beat.data_byte      = data;
    beat.byte_valid     = valid;
    beat.end_of_packet  = eop;
    beat.packet_bits    = bits;
    beat.overload_total = overload_tally;
    expected_beats.push_back(beat);
  endfunction

  // Quantize one accepted sample and queue the beats it produces.
  function void note_sample(logic signed [31:0] value, logic is_last);
    logic [16:0] levels;
    int          width;
    logic [15:0] code;
    longint      diff;
    logic [63:0] prod;
    logic [63:0] q;
    logic        bitv;
    samples_noted++;
    levels = level_count;
    if (levels < 17'd2) levels = 17'd2;
    if (levels > 17'(LEVEL_MAX)) levels = 17'(LEVEL_MAX);
    width = 0;
    while ((32'd1 << width) < levels) width++;

    if (value < range_low) begin
      if (overload_tally != '1) overload_tally++;
      code = '0;
    end else if (value > range_high) begin
      if (overload_tally != '1) overload_tally++;
      code = 16'(levels - 17'd1);
    end else begin
      diff = longint'(value) - longint'(range_low);
      prod = 64'(diff) * {32'd0, inv_step};
      q    = ((prod >> 31) + 64'd1) >> 1;
      code = (q >= 64'(levels)) ? 16'(levels - 17'd1) : q[15:0];
    end

    for (int b = 0; b < width; b++) begin
      bitv = code[b];
      // drop bits once the packet is full
      if (bit_position >= 10'(PACKET_CAP)) break;
      bit_position++;
      if (pending_count == 3'd7) begin
        push_beat({bitv, pending_bits}, 1'b1, 1'b0, '0);
        pending_bits  = '0;
        pending_count = '0;
      end else begin
        pending_bits[pending_count] = bitv;
        pending_count++;
      end
    end

    if (is_last) begin
      if (pending_count != '0) push_beat({1'b0, pending_bits}, 1'b1, 1'b1, bit_position);
      else push_beat(8'd0, 1'b0, 1'b1, bit_position);
      pending_bits   = '0;
      pending_count  = '0;
      bit_position   = '0;
      packets_closed++;
    end
  endfunction

  function void check_beat(packed_beat_t got);
    packed_beat_t want;
    beats_checked++;
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected beat: byte %02h valid %0b eop %0b bits %0d ovl %0d",
                 $time, got.data_byte, got.byte_valid, got.end_of_packet,
                 got.packet_bits, got.overload_total);
      return;
    end
    want = expected_beats.pop_front();
    if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
        got.end_of_packet !== want.end_of_packet || got.packet_bits !== want.packet_bits ||
        got.overload_total !== want.overload_total) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: beat mismatch, expected byte %02h valid %0b eop %0b bits %0d ovl %0d",
                 $time, want.data_byte, want.byte_valid, want.end_of_packet,
                 want.packet_bits, want.overload_total);
        $display("%0t:                  actual byte %02h valid %0b eop %0b bits %0d ovl %0d",
                 $time, got.data_byte, got.byte_valid, got.end_of_packet,
                 got.packet_bits, got.overload_total);
      end
    end
  endfunction
endclass

module quantize_and_bitpack_encoder_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_AFTER     = 40;
  localparam int HOLD_CYCLES    = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] sample_value_i;
  logic        last_sample_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  data_byte_o;
  logic        byte_valid_o;
  logic        end_of_packet_o;
  logic [9:0]  packet_bits_o;
  logic [31:0] overload_total_o;

  packing_scoreboard sb;
  bit idle_on;
  int hold_left;
  bit hold_done;

  quantize_and_bitpack_encoder u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .sample_value_i,
    .last_sample_i,
    .out_valid_o,
    .out_ready_i,
    .data_byte_o,
    .byte_valid_o,
    .end_of_packet_o,
    .packet_bits_o,
    .overload_total_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic write_reg(input qbe_pkg::qbe_reg_e idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] inv, input logic [31:0] levels);
    write_reg(qbe_pkg::REG_RANGE_LOW, lo);
    write_reg(qbe_pkg::REG_RANGE_HIGH, hi);
    write_reg(qbe_pkg::REG_INV_STEP, inv);
    write_reg(qbe_pkg::REG_LEVEL_COUNT, levels);
  endtask

  // Drop valid, wait for every expected beat, then let beatless samples drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_sample(input logic signed [31:0] value, input logic is_last);
    if (idle_on) begin
      while ($urandom_range(99) < 23) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    last_sample_i  <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_sample(value, is_last);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_sample();
    longint      span;
    logic [63:0] wide;
    case ($urandom_range(9)) inside
      [0:5]: begin
        if (sb.range_low > sb.range_high) return $urandom;
        span = longint'(sb.range_high) - longint'(sb.range_low) + 1;
        wide = {$urandom, $urandom};
        return 32'(longint'(sb.range_low) + longint'(wide % 64'(span)));
      end
      6: return sb.range_low + 32'($urandom_range(2)) - 32'sd1;
      7: return sb.range_high + 32'($urandom_range(2)) - 32'sd1;
      8: return $urandom;
      default: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endcase
  endfunction

  task automatic send_packet(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample(), i == count - 1);
  endtask

  // level_mode: 0 all 65536 levels, 1 from 2 to 1000 levels, 2 any 17-bit count
  task automatic random_setting(input int level_mode);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] t;
    logic [16:0]        levels;
    logic [31:0]        inv;
    longint             span;
    longint             ratio;
    lo = $urandom;
    hi = $urandom;
    if ($urandom_range(2) == 0) hi = lo + 32'($urandom_range(1 << 22));
    else if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    case (level_mode)
      0:       levels = 17'd65536;
      1:       levels = 17'($urandom_range(2, 1000));
      default: levels = 17'($urandom);
    endcase
    span = longint'(hi) - longint'(lo);
    if (span <= 0) inv = $urandom;
    else begin
      ratio = (longint'(levels) <<< 32) / span;
      inv   = (ratio > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(ratio);
    end
    if ($urandom_range(4) == 0) inv = $urandom;
    apply_setting(lo, hi, inv, {15'($urandom), levels});
  endtask

  // Receiver: random back-pressure when idle_on is set, plus one long hold-off while input keeps coming.
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    hold_done   = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.samples_noted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_on && $urandom_range(99) < 23);
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_beat('{data_byte: data_byte_o, byte_valid: byte_valid_o,
                        end_of_packet: end_of_packet_o, packet_bits: packet_bits_o,
                        overload_total: overload_total_o});
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int sent;
    int n;
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = qbe_pkg::REG_RANGE_LOW;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    sample_value_i = '0;
    last_sample_i  = 1'b0;
    idle_on        = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: range edges, overloads both ways, end marker with no partial byte.
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd655360, 1'b0);
    send_sample(32'sd655360, 1'b0);
    send_sample(-32'sd655361, 1'b0);
    send_sample(32'sd655361, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    settle();

    // Half-step rounding goes up, index clamps at the top, partial byte flushed.
    apply_setting(32'sd0, 32'sh7FFF_FFFF, 32'h0000_8000, 32'd5);
    send_sample(32'sd65535, 1'b0);
    send_sample(32'sd65536, 1'b0);
    send_sample(32'sd196608, 1'b0);
    send_sample(32'sd589824, 1'b0);
    send_sample(-32'sd1, 1'b1);
    settle();

    // Inverted range, level count of zero with junk in the upper data bits.
    apply_setting(32'sd65536, -32'sd65536, 32'h0001_0000, 32'hFFFE_0000);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd100000, 1'b0);
    send_sample(-32'sd100000, 1'b0);
    send_sample(32'sd65536, 1'b1);
    settle();

    // Single-value range, level count of one.
    apply_setting(32'sd0, 32'sd0, 32'h0001_0000, 32'd1);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(-32'sd1, 1'b1);
    settle();

    // Full range, largest step, level count past the maximum.
    apply_setting(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_FFFF);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sh4000_0000, 1'b1);
    settle();

    // One long 16-bit packet that overruns the packet capacity.
    apply_setting(32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0001_0000, 32'd65536);
    send_packet(36);
    settle();

    for (int phase = 1; phase <= 5; phase++) begin
      idle_on = (phase != 2);
      case (phase) inside
        [1:2]:   random_setting(1);
        4:       random_setting(0);
        default: random_setting(2);
      endcase
      sent = 0;
      while (sent < 8) begin
        n = $urandom_range(1, 8);
        send_packet(n);
        sent += n;
      end
      settle();
    end
    idle_on = 1'b1;

    $display("run covered %0d samples in %0d packets over 11 settings, %0d overloads",
             sb.samples_noted, sb.packets_closed, sb.overload_tally);
    $display("%0d result beats checked, %0d mismatched", sb.beats_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/qbe_pkg.sv
rtl/core/qbe_front.sv
rtl/core/qbe_fifo.sv
rtl/core/qbe_back.sv
rtl/core/quantize_and_bitpack_encoder.sv
rtl/core/qbe_checker.sv
tb/sv/quantize_and_bitpack_encoder_tb.sv
